// File: hdl/rse_pkg.sv
// rse_pkg: shared types and constants for the rank sort engine.
// Holds the datapath command/status structs and the operation codes.
// No dependencies.
package rse_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAPACITY_DEF = 32;

  // Datapath operation selected by the controller
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_CMP   = 2'd1,
    OP_PLACE = 2'd2,
    OP_EMIT  = 2'd3
  } dp_op_t;

  // Controller to datapath commands
  typedef struct packed {
    dp_op_t op;
    logic   load;     // take the incoming request
    logic   commit;   // write the new rank, bump the element count
    logic   restart;  // rewind the scan index
    logic   clear;    // drop the set, rewind everything
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // scan reached the count, no read in flight
    logic flush;      // set ends with the element being ranked
  } dp_stat_t;

endpackage

// File: hdl/rse_datapath.sv
// rse_datapath: value, rank and placed memories with the scan pipeline
// and the result register for the rank sort engine.
// Depends on rse_pkg.
module rse_datapath #(
  parameter int unsigned CAPACITY = rse_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rse_pkg::dp_cmd_t                    cmd,
  output rse_pkg::dp_stat_t                   stat,
  input  logic signed [rse_pkg::DATA_W-1:0]   in_value,
  input  logic                                in_last_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rse_pkg::DATA_W-1:0]   out_sorted_value,
  output logic                                out_last_out
);
  import rse_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Storage
  logic signed [DATA_W-1:0] value_mem  [CAPACITY];
  logic        [IDX_W-1:0]  rank_mem   [CAPACITY];
  logic signed [DATA_W-1:0] placed_mem [CAPACITY];

  // Control registers
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [CNT_W-1:0] scan_r,  scan_nxt;
  logic             p_vld_r;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers
  logic [CNT_W-1:0]         p_idx_r;
  logic signed [DATA_W-1:0] v_r;
  logic                     last_r;
  logic [IDX_W-1:0]         newrank_r;
  logic signed [DATA_W-1:0] val_rd_r;
  logic [IDX_W-1:0]         rank_rd_r;
  logic signed [DATA_W-1:0] plc_rd_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;

  logic issue;
  logic scan_more;
  logic earlier_le;
  logic out_free;

  assign scan_more  = (scan_r != cnt_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign earlier_le = (val_rd_r <= v_r);

  // Cmp/place read every cycle; emit needs a free result slot, no read pending
  always_comb begin
    case (cmd.op)
      OP_CMP, OP_PLACE: issue = scan_more;
      OP_EMIT:          issue = scan_more && !p_vld_r && out_free;
      default:          issue = 1'b0;
    endcase
  end

  assign stat.scan_done = !scan_more && !p_vld_r;
  assign stat.flush     = last_r || (cnt_r == CNT_W'(CAPACITY - 1));

  // Next count and scan index
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.commit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    scan_nxt = scan_r;
    if (cmd.load || cmd.commit || cmd.restart || cmd.clear) begin
      scan_nxt = '0;
    end else if (issue) begin
      scan_nxt = scan_r + CNT_W'(1);
    end
  end

  // Load the result register when emit data returns, drop it when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (p_vld_r && cmd.op == OP_EMIT) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      scan_r      <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      p_vld_r     <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the new request and keep its running rank
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r       <= in_value;
      last_r    <= in_last_in;
      newrank_r <= '0;
    end else if (cmd.op == OP_CMP && p_vld_r && earlier_le) begin
      newrank_r <= newrank_r + IDX_W'(1);
    end
    if (issue) begin
      p_idx_r <= scan_r;
    end
  end

  // Value store: write on load, registered read at the scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_mem[cnt_r[IDX_W-1:0]] <= in_value;
    end
    if (issue) begin
      val_rd_r <= value_mem[scan_r[IDX_W-1:0]];
    end
  end

  // Rank store: bump a greater earlier element, or write the new rank
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rank_mem[cnt_r[IDX_W-1:0]] <= newrank_r;
    end else if (cmd.op == OP_CMP && p_vld_r && !earlier_le) begin
      rank_mem[p_idx_r[IDX_W-1:0]] <= rank_rd_r + IDX_W'(1);
    end
    if (issue) begin
      rank_rd_r <= rank_mem[scan_r[IDX_W-1:0]];
    end
  end

  // Placed store: scatter by rank, read back in order
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PLACE && p_vld_r) begin
      placed_mem[rank_rd_r] <= val_rd_r;
    end
    if (issue) begin
      plc_rd_r <= placed_mem[scan_r[IDX_W-1:0]];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (p_vld_r && cmd.op == OP_EMIT) begin
      out_value_r <= plc_rd_r;
      out_last_r  <= (p_idx_r == cnt_r - CNT_W'(1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;

endmodule

// File: hdl/rse_ctrl.sv
// rse_ctrl: sequencing state machine for the rank sort engine.
// Drives datapath commands from its status and the input handshake.
// Depends on rse_pkg.
module rse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output rse_pkg::dp_cmd_t   cmd,
  input  rse_pkg::dp_stat_t  stat
);
  import rse_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PLACE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Decode commands and next state
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.op      = OP_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.op = OP_CMP;
        if (stat.scan_done) begin
          cmd.commit = 1'b1;
          state_nxt  = stat.flush ? ST_PLACE : ST_IDLE;
        end
      end
      ST_PLACE: begin
        cmd.op = OP_PLACE;
        if (stat.scan_done) begin
          cmd.restart = 1'b1;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.op = OP_EMIT;
        if (stat.scan_done) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/rank_sort_engine_core.sv
// rank_sort_engine_core: stable rank sort of signed 32-bit values.
// An item with k earlier elements in its set goes through: accept, one value/rank memory
// read per earlier element, a read-pipe drain when k is not 0, rank write-back.
// The set is then placed by rank, and its results are emitted one read at a time
// through the single placed-store read port and result register.
// Synchronous active-low reset empties the set; memories are not cleared.
module rank_sort_engine_core #(
  parameter int unsigned CAPACITY = rse_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rse_pkg::DATA_W-1:0]   in_value,
  input  logic                                in_last_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rse_pkg::DATA_W-1:0]   out_sorted_value,
  output logic                                out_last_out
);
  import rse_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  rse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Storage and scan datapath
  rse_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out)
  );

endmodule
